FILE: rtl/dcrf_pkg.sv
// ----------------------------------------------------------------------------
// DHCP client receive filter package
// Shared payload types, reason codes and register indexes.
// ----------------------------------------------------------------------------
package dcrf_pkg;

   localparam int unsigned PosWidth = 7;
   localparam int unsigned SumWidth = 21;

   localparam logic [PosWidth-1:0] PosMax          = 7'd127;
   localparam logic [PosWidth-1:0] PosEtherHi      = 7'd12;
   localparam logic [PosWidth-1:0] PosEtherLo      = 7'd13;
   localparam logic [PosWidth-1:0] PosIpStart      = 7'd14;
   localparam logic [PosWidth-1:0] PosProtocol     = 7'd23;
   localparam logic [PosWidth-1:0] PosChecksumHi   = 7'd24;
   localparam logic [PosWidth-1:0] PosChecksumLo   = 7'd25;
   localparam logic [PosWidth-1:0] PosSourceFirst  = 7'd26;
   localparam logic [PosWidth-1:0] PosSourceLast   = 7'd29;
   localparam logic [PosWidth-1:0] PosDestFirst    = 7'd30;
   localparam logic [PosWidth-1:0] PosDestLast     = 7'd33;
   localparam logic [PosWidth-1:0] PosPortHi       = 7'd36;
   localparam logic [PosWidth-1:0] PosPortLo       = 7'd37;
   localparam logic [PosWidth-1:0] PosLengthHi     = 7'd38;
   localparam logic [PosWidth-1:0] PosLengthLo     = 7'd39;
   localparam logic [PosWidth-1:0] NeedEther       = 7'd14;
   localparam logic [PosWidth-1:0] NeedPort        = 7'd38;
   localparam logic [PosWidth-1:0] NeedLength      = 7'd40;

   localparam logic [15:0] EthertypeIpv4 = 16'h0800;
   localparam logic [7:0]  ProtoUdp      = 8'h11;
   localparam logic [31:0] AllOnesAddr   = 32'hffff_ffff;
   localparam logic [3:0]  MinHeaderWords = 4'd5;

   localparam logic [31:0] ServerIpReset     = 32'd0;
   localparam logic [31:0] OwnIpReset        = 32'd0;
   localparam logic [15:0] ClientPortReset   = 16'd68;
   localparam logic [15:0] MinUdpLengthReset = 16'd236;

   typedef enum logic [1:0] {
      CSR_SERVER_IP      = 2'd0,
      CSR_OWN_IP         = 2'd1,
      CSR_CLIENT_PORT    = 2'd2,
      CSR_MIN_UDP_LENGTH = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      REASON_OK        = 4'd0,
      REASON_NOT_IPV4  = 4'd1,
      REASON_CHECKSUM  = 4'd2,
      REASON_NOT_UDP   = 4'd3,
      REASON_SOURCE    = 4'd4,
      REASON_DEST      = 4'd5,
      REASON_PORT      = 4'd6,
      REASON_SHORT     = 4'd7,
      REASON_TRUNCATED = 4'd8
   } reason_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        accept;
      logic [3:0]  reason;
      logic [15:0] udp_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0] server_ip;
      logic [31:0] own_ip;
      logic [15:0] client_port;
      logic [15:0] min_udp_length;
   } cfg_type;

   typedef struct packed {
      logic [PosWidth-1:0] byte_position;
      logic [SumWidth-1:0] sum_accumulator;
      logic [7:0]          high_byte_hold;
      logic [15:0]         ether_type;
      logic [3:0]          header_words;
      logic [15:0]         header_checksum;
      logic [7:0]          protocol_number;
      logic [31:0]         source_address;
      logic [31:0]         target_address;
      logic [15:0]         target_port;
      logic [15:0]         udp_length_field;
   } frame_type;

endpackage

FILE: rtl/dcrf_csr.sv
// ----------------------------------------------------------------------------
// DHCP client receive filter registers
// Holds the filter settings written through the register port.
// ----------------------------------------------------------------------------
module dcrf_csr import dcrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.server_ip      <= ServerIpReset;
         cfg_ff.own_ip         <= OwnIpReset;
         cfg_ff.client_port    <= ClientPortReset;
         cfg_ff.min_udp_length <= MinUdpLengthReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SERVER_IP:      cfg_ff.server_ip      <= csr_wdata;
            CSR_OWN_IP:         cfg_ff.own_ip         <= csr_wdata;
            CSR_CLIENT_PORT:    cfg_ff.client_port    <= csr_wdata[15:0];
            CSR_MIN_UDP_LENGTH: cfg_ff.min_udp_length <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/dcrf_parse.sv
// ----------------------------------------------------------------------------
// DHCP client receive filter header capture
// Tracks the byte position, captures header fields and sums the IPv4 header.
// ----------------------------------------------------------------------------
module dcrf_parse import dcrf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      take,
   input  req_type   item,
   output frame_type view
);

   frame_type frame_ff;
   frame_type frame_in;

   logic [PosWidth-1:0] pos;
   logic [7:0]          b;
   logic [PosWidth-1:0] header_end;
   logic                in_header;

   always_comb begin
      pos      = frame_ff.byte_position;
      b        = item.frame_byte;
      frame_in = frame_ff;
      if (pos != PosMax) begin
         if (pos == PosEtherHi || pos == PosEtherLo) begin
            frame_in.ether_type = {frame_ff.ether_type[7:0], b};
         end
         if (pos == PosIpStart) begin
            frame_in.header_words = b[3:0];
         end
         if (pos == PosProtocol) begin
            frame_in.protocol_number = b;
         end
         if (pos == PosChecksumHi || pos == PosChecksumLo) begin
            frame_in.header_checksum = {frame_ff.header_checksum[7:0], b};
         end
         if (pos >= PosSourceFirst && pos <= PosSourceLast) begin
            frame_in.source_address = {frame_ff.source_address[23:0], b};
         end
         if (pos >= PosDestFirst && pos <= PosDestLast) begin
            frame_in.target_address = {frame_ff.target_address[23:0], b};
         end
         if (pos == PosPortHi || pos == PosPortLo) begin
            frame_in.target_port = {frame_ff.target_port[7:0], b};
         end
         if (pos == PosLengthHi || pos == PosLengthLo) begin
            frame_in.udp_length_field = {frame_ff.udp_length_field[7:0], b};
         end
      end
      header_end = PosIpStart + {1'b0, frame_in.header_words, 2'b00};
      in_header  = (pos != PosMax) && (pos >= PosIpStart) && (pos < header_end) &&
                   (pos != PosChecksumHi) && (pos != PosChecksumLo);
      if (in_header) begin
         if (!pos[0]) begin
            frame_in.high_byte_hold = b;
         end else begin
            frame_in.sum_accumulator = frame_ff.sum_accumulator +
                                       {5'd0, frame_ff.high_byte_hold, b};
         end
      end
      frame_in.byte_position = (pos != PosMax) ? pos + 7'd1 : PosMax;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (take) begin
         if (item.last_byte) begin
            frame_ff <= '0;
         end else begin
            frame_ff <= frame_in;
         end
      end
   end

   assign view = frame_in;

endmodule

FILE: rtl/dcrf_judge.sv
// ----------------------------------------------------------------------------
// DHCP client receive filter judgment
// Runs the ordered frame checks and forms the result of a finished frame.
// ----------------------------------------------------------------------------
module dcrf_judge import dcrf_pkg::*; (
   input  cfg_type   cfg,
   input  frame_type view,
   output rsp_type   result
);

   logic [16:0]         fold1;
   logic [16:0]         fold2;
   logic [15:0]         checksum;
   logic [PosWidth-1:0] n;
   logic [PosWidth-1:0] header_end;
   reason_type          reason;

   always_comb begin
      n          = view.byte_position;
      header_end = PosIpStart + {1'b0, view.header_words, 2'b00};
      fold1      = {12'd0, view.sum_accumulator[20:16]} + {1'b0, view.sum_accumulator[15:0]};
      fold2      = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
      checksum   = ~fold2[15:0];
      priority if (n < NeedEther) begin
         reason = REASON_TRUNCATED;
      end else if (view.ether_type != EthertypeIpv4) begin
         reason = REASON_NOT_IPV4;
      end else if (view.header_words < MinHeaderWords || n < header_end) begin
         reason = REASON_TRUNCATED;
      end else if (checksum != view.header_checksum) begin
         reason = REASON_CHECKSUM;
      end else if (view.protocol_number != ProtoUdp) begin
         reason = REASON_NOT_UDP;
      end else if (cfg.server_ip != '0 && cfg.server_ip != view.source_address) begin
         reason = REASON_SOURCE;
      end else if (cfg.own_ip != '0 && cfg.own_ip != view.target_address &&
                   view.target_address != AllOnesAddr) begin
         reason = REASON_DEST;
      end else if (n < NeedPort) begin
         reason = REASON_TRUNCATED;
      end else if (view.target_port != cfg.client_port) begin
         reason = REASON_PORT;
      end else if (n < NeedLength) begin
         reason = REASON_TRUNCATED;
      end else if (view.udp_length_field < cfg.min_udp_length) begin
         reason = REASON_SHORT;
      end else begin
         reason = REASON_OK;
      end
      result.accept     = (reason == REASON_OK);
      result.reason     = reason;
      result.udp_length = (n >= NeedLength) ? view.udp_length_field : 16'd0;
   end

endmodule

FILE: rtl/dhcp_client_rx_frame_filter.sv
// ----------------------------------------------------------------------------
// DHCP client receive filter
// Checks streamed Ethernet frames for IPv4/UDP traffic meant for a DHCP client.
// ----------------------------------------------------------------------------
// The frame enters on the req_ channel one byte per transfer, destination
// MAC first, with last_byte set on the final byte. For each frame the block
// returns exactly one transfer on the rsp_ channel: accept, a reason code
// and the UDP length field. Bytes other than the final one cause no result.
// The csr_ channel writes the server address, own address, client port and
// minimum UDP length; it is always ready and should be used between frames.
// Each byte is held in an input register and processed from there; the
// result is formed when the final byte leaves the input register and
// appears in the output register, which drives rsp_valid. One byte is
// taken every cycle, limited only by the result register: while a result
// waits on rsp_ready, bytes before the next final byte still flow, and a
// second final byte waits in the input register.
// Reset clears both registers, all captured header state and restores the
// register defaults (client port 68, minimum UDP length 236).
// ----------------------------------------------------------------------------
module dhcp_client_rx_frame_filter import dcrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata
);

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   logic      advance;
   cfg_type   cfg;
   frame_type view;
   rsp_type   result;

   assign advance   = in_valid_ff && (!in_data_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_data_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_data_ff.last_byte) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dcrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dcrf_parse u_parse (
      .clock (clock),
      .reset (reset),
      .take  (advance),
      .item  (in_data_ff),
      .view  (view)
   );

   dcrf_judge u_judge (
      .cfg    (cfg),
      .view   (view),
      .result (result)
   );

endmodule

FILE: rtl/dcrf_checker.sv
// ----------------------------------------------------------------------------
// DHCP client receive filter checker
// Port-level assertions on the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dcrf_checker import dcrf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result transfer keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Accept is set exactly when the reason code reports a clean frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.accept == (rsp_data.reason == REASON_OK)))
      else $error("accept and reason disagree");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.reason <= REASON_TRUNCATED))
      else $error("reason code out of range");

   // After reset no result is pending and the input side is open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind dhcp_client_rx_frame_filter dcrf_checker u_dcrf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DHCP client receive filter testbench
// Streams Ethernet frames into the filter byte by byte and compares every
// verdict with the one worked out by a byte-level model kept in the bench.
// Directed frames cover each reason code, truncation points, long frames and
// register extremes; random phases mix well-formed frames with broken ones
// and noise, the first with both sides idling at random, and one phase
// holds the receiver off long enough for the filter to stall its input.
// ----------------------------------------------------------------------------
module tb_top;
   import dcrf_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned DrainCycles = 8;

   typedef enum int {
      SHAPE_GOOD,
      SHAPE_BAD_ETHERTYPE,
      SHAPE_BAD_CHECKSUM,
      SHAPE_NOT_UDP,
      SHAPE_WRONG_SOURCE,
      SHAPE_WRONG_DEST,
      SHAPE_BROADCAST_DEST,
      SHAPE_WRONG_PORT,
      SHAPE_SHORT_UDP,
      SHAPE_LOW_IHL,
      SHAPE_OPTIONS
   } frame_shape_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SERVER_IP;
   logic [31:0]   csr_wdata = '0;

   cfg_type       filter_cfg;
   frame_type     filter_frame;
   rsp_type       expected_verdicts[$];
   logic [7:0]    frame_buf [0:255];

   int unsigned   mismatch_count = 0;
   int unsigned   verdict_count = 0;
   int unsigned   bytes_sent = 0;
   int unsigned   cycle_count = 0;
   bit            gaps_on = 1'b0;
   int unsigned   hold_length = 0;
   int unsigned   hold_requests = 0;
   int unsigned   hold_seen = 0;
   int unsigned   hold_left = 0;
   int unsigned   stall_left = 0;

   dhcp_client_rx_frame_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Byte-level model of the filter; queues a verdict on every final byte.
   task automatic filter_take(input req_type item);
      int unsigned p;
      int unsigned n;
      int unsigned header_end;
      logic [31:0] folded;
      logic [15:0] computed;
      logic [7:0]  b;
      rsp_type     verdict;
      reason_type  why;
      b = item.frame_byte;
      p = filter_frame.byte_position;
      if (p < PosMax) begin
         if (p == PosEtherHi || p == PosEtherLo)
            filter_frame.ether_type = {filter_frame.ether_type[7:0], b};
         if (p == PosIpStart)
            filter_frame.header_words = b[3:0];
         if (p == PosProtocol)
            filter_frame.protocol_number = b;
         if (p == PosChecksumHi || p == PosChecksumLo)
            filter_frame.header_checksum = {filter_frame.header_checksum[7:0], b};
         if (p >= PosSourceFirst && p <= PosSourceLast)
            filter_frame.source_address = {filter_frame.source_address[23:0], b};
         if (p >= PosDestFirst && p <= PosDestLast)
            filter_frame.target_address = {filter_frame.target_address[23:0], b};
         if (p == PosPortHi || p == PosPortLo)
            filter_frame.target_port = {filter_frame.target_port[7:0], b};
         if (p == PosLengthHi || p == PosLengthLo)
            filter_frame.udp_length_field = {filter_frame.udp_length_field[7:0], b};
         header_end = PosIpStart + 4 * filter_frame.header_words;
         if (p >= PosIpStart && p < header_end && p != PosChecksumHi && p != PosChecksumLo) begin
            if ((p - PosIpStart) % 2 == 0)
               filter_frame.high_byte_hold = b;
            else
               filter_frame.sum_accumulator = filter_frame.sum_accumulator +
                                              {filter_frame.high_byte_hold, b};
         end
         n = p + 1;
      end else begin
         n = PosMax;
      end
      filter_frame.byte_position = 7'(n);
      if (item.last_byte) begin
         header_end = PosIpStart + 4 * filter_frame.header_words;
         folded = 32'(filter_frame.sum_accumulator[20:16]) +
                  32'(filter_frame.sum_accumulator[15:0]);
         folded = folded + (folded >> 16);
         computed = ~folded[15:0];
         if (n < NeedEther)
            why = REASON_TRUNCATED;
         else if (filter_frame.ether_type != EthertypeIpv4)
            why = REASON_NOT_IPV4;
         else if (filter_frame.header_words < MinHeaderWords || n < header_end)
            why = REASON_TRUNCATED;
         else if (computed != filter_frame.header_checksum)
            why = REASON_CHECKSUM;
         else if (filter_frame.protocol_number != ProtoUdp)
            why = REASON_NOT_UDP;
         else if (filter_cfg.server_ip != 0 &&
                  filter_cfg.server_ip != filter_frame.source_address)
            why = REASON_SOURCE;
         else if (filter_cfg.own_ip != 0 && filter_cfg.own_ip != filter_frame.target_address &&
                  filter_frame.target_address != AllOnesAddr)
            why = REASON_DEST;
         else if (n < NeedPort)
            why = REASON_TRUNCATED;
         else if (filter_frame.target_port != filter_cfg.client_port)
            why = REASON_PORT;
         else if (n < NeedLength)
            why = REASON_TRUNCATED;
         else if (filter_frame.udp_length_field < filter_cfg.min_udp_length)
            why = REASON_SHORT;
         else
            why = REASON_OK;
         verdict.accept = (why == REASON_OK);
         verdict.reason = why;
         verdict.udp_length = (n >= NeedLength) ? filter_frame.udp_length_field : 16'd0;
         expected_verdicts.push_back(verdict);
         filter_frame = '0;
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      req_type item;
      item = '{frame_byte: value, last_byte: last};
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      filter_take(item);
      bytes_sent++;
   endtask

   task automatic send_frame(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_byte(frame_buf[i % 256], i == len - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SERVER_IP:      filter_cfg.server_ip = data;
         CSR_OWN_IP:         filter_cfg.own_ip = data;
         CSR_CLIENT_PORT:    filter_cfg.client_port = data[15:0];
         CSR_MIN_UDP_LENGTH: filter_cfg.min_udp_length = data[15:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_registers(input logic [31:0] server, input logic [31:0] own,
                                 input logic [15:0] port, input logic [15:0] min_length);
      drain();
      write_register(CSR_SERVER_IP, server);
      write_register(CSR_OWN_IP, own);
      write_register(CSR_CLIENT_PORT, {16'($urandom), port});
      write_register(CSR_MIN_UDP_LENGTH, {16'($urandom), min_length});
   endtask

   function automatic void put_word(input int unsigned pos, input logic [15:0] value);
      frame_buf[pos] = value[15:8];
      frame_buf[pos + 1] = value[7:0];
   endfunction

   function automatic void put_addr(input int unsigned pos, input logic [31:0] value);
      put_word(pos, value[31:16]);
      put_word(pos + 2, value[15:0]);
   endfunction

   function automatic void seal_checksum();
      logic [31:0] total;
      int unsigned stop;
      total = 0;
      stop = PosIpStart + 4 * frame_buf[PosIpStart][3:0];
      for (int unsigned k = PosIpStart; k < stop; k += 2)
         if (k != PosChecksumHi)
            total += {frame_buf[k], frame_buf[k + 1]};
      total = total[15:0] + total[31:16];
      total = total[15:0] + total[31:16];
      put_word(PosChecksumHi, ~total[15:0]);
   endfunction

   // Fills frame_buf with a frame of the given shape and returns its natural length plus zero to six extra bytes.
   function automatic int unsigned build_shaped(input frame_shape_type shape);
      int unsigned ihl;
      int unsigned wide;
      int unsigned natural_len;
      int unsigned flip_pos;
      logic [15:0] ulen;
      logic [3:0]  version;
      wide = filter_cfg.min_udp_length + $urandom_range(0, 40);
      ulen = (wide > 65535) ? 16'hffff : 16'(wide);
      if (shape == SHAPE_SHORT_UDP)
         ulen = (filter_cfg.min_udp_length == 0) ? 16'd0 :
                16'($urandom_range(0, filter_cfg.min_udp_length - 1));
      for (int i = 0; i < 256; i++)
         frame_buf[i] = 8'($urandom);
      put_word(PosEtherHi, EthertypeIpv4);
      frame_buf[PosProtocol] = ProtoUdp;
      put_addr(PosSourceFirst, (filter_cfg.server_ip != 0) ? filter_cfg.server_ip : $urandom);
      put_addr(PosDestFirst, (filter_cfg.own_ip != 0) ? filter_cfg.own_ip : $urandom);
      put_word(PosPortHi, filter_cfg.client_port);
      put_word(PosLengthHi, ulen);
      ihl = 5;
      case (shape)
         SHAPE_BAD_ETHERTYPE:
            put_word(PosEtherHi, EthertypeIpv4 ^ 16'($urandom_range(1, 65535)));
         SHAPE_NOT_UDP:
            frame_buf[PosProtocol] = ProtoUdp ^ 8'($urandom_range(1, 255));
         SHAPE_WRONG_SOURCE:   put_addr(PosSourceFirst, $urandom);
         SHAPE_WRONG_DEST:     put_addr(PosDestFirst, $urandom);
         SHAPE_BROADCAST_DEST: put_addr(PosDestFirst, AllOnesAddr);
         SHAPE_WRONG_PORT:
            put_word(PosPortHi, filter_cfg.client_port ^ 16'($urandom_range(1, 65535)));
         SHAPE_LOW_IHL:        ihl = $urandom_range(0, 4);
         SHAPE_OPTIONS:        ihl = $urandom_range(6, 15);
         default: ;
      endcase
      version = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4;
      frame_buf[PosIpStart] = {version, 4'(ihl)};
      seal_checksum();
      if (shape == SHAPE_BAD_CHECKSUM) begin
         flip_pos = PosChecksumHi + $urandom_range(0, 1);
         frame_buf[flip_pos] = frame_buf[flip_pos] ^ 8'(1 << $urandom_range(0, 7));
      end
      natural_len = PosIpStart + 4 * ihl;
      if (natural_len < NeedLength)
         natural_len = NeedLength;
      return natural_len + $urandom_range(0, 6);
   endfunction

   always @(posedge clock) begin : check_verdict
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdict_count++;
         if (expected_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: result with nothing pending: accept=%0b reason=%0d len=%0d",
                        rsp_data.accept, rsp_data.reason, rsp_data.udp_length);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_data.accept !== want.accept || rsp_data.reason !== want.reason ||
                rsp_data.udp_length !== want.udp_length) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR: result %0d: expected accept=%0b reason=%0d len=%0d, ",
                            "got accept=%0b reason=%0d len=%0d"}, verdict_count,
                           want.accept, want.reason, want.udp_length,
                           rsp_data.accept, rsp_data.reason, rsp_data.udp_length);
            end
         end
      end
   end

   // Receiver side: random stall bursts, plus long hold-offs on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = hold_length;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic test_reset_defaults();
      void'(build_shaped(SHAPE_GOOD));
      put_word(PosLengthHi, MinUdpLengthReset);
      seal_checksum();
      send_frame(42);
      void'(build_shaped(SHAPE_SHORT_UDP));
      put_word(PosLengthHi, MinUdpLengthReset - 16'd1);
      seal_checksum();
      send_frame(40);
   endtask

   task automatic test_reason_codes();
      frame_shape_type shape;
      load_registers($urandom_range(1, 32'hffff_fffe), $urandom_range(1, 32'hffff_fffe),
                     16'($urandom), 16'd100);
      shape = shape.first();
      do begin
         send_frame(build_shaped(shape));
         shape = shape.next();
      end while (shape != shape.first());
   endtask

   task automatic test_truncated_frames();
      int unsigned cuts [5] = '{13, 20, 34, 38, 39};
      foreach (cuts[i]) begin
         void'(build_shaped(SHAPE_GOOD));
         send_frame(cuts[i]);
      end
   endtask

   task automatic test_long_frames();
      void'(build_shaped(SHAPE_GOOD));
      send_frame(128);
   endtask

   task automatic test_register_extremes();
      load_registers(AllOnesAddr, AllOnesAddr, 16'hffff, 16'hffff);
      send_frame(build_shaped(SHAPE_SHORT_UDP));
      send_frame(build_shaped(SHAPE_WRONG_DEST));
      load_registers(32'd0, 32'd0, 16'd0, 16'd0);
      send_frame(build_shaped(SHAPE_WRONG_SOURCE));
   endtask

   task automatic test_receiver_hold_off();
      drain();
      gaps_on = 1'b0;
      hold_length = 400;
      hold_requests++;
      repeat (12) begin
         void'(build_shaped(SHAPE_GOOD));
         send_frame($urandom_range(1, 3));
      end
      send_frame(build_shaped(SHAPE_GOOD));
      drain();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_frames(input bit with_gaps, input int unsigned byte_target,
                                     input int unsigned verdict_target);
      int unsigned start_bytes;
      int unsigned start_verdicts;
      int unsigned pick;
      int unsigned len;
      logic [31:0] own;
      frame_shape_type shape;
      case ($urandom_range(0, 2))
         0:       own = 32'd0;
         1:       own = $urandom;
         default: own = AllOnesAddr;
      endcase
      load_registers(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom, own,
                     ($urandom_range(0, 3) == 0) ? ClientPortReset : 16'($urandom),
                     16'($urandom_range(0, 600)));
      gaps_on = with_gaps;
      start_bytes = bytes_sent;
      start_verdicts = verdict_count;
      while (bytes_sent - start_bytes < byte_target ||
             verdict_count - start_verdicts < verdict_target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            for (int i = 0; i < 256; i++)
               frame_buf[i] = 8'($urandom);
            send_frame($urandom_range(1, 60));
         end else begin
            shape = (pick < 50) ? SHAPE_GOOD :
                    frame_shape_type'($urandom_range(SHAPE_GOOD, SHAPE_OPTIONS));
            len = build_shaped(shape);
            pick = $urandom_range(0, 99);
            if (pick < 8)
               len = $urandom_range(1, len - 1);
            else if (pick < 10)
               len = $urandom_range(120, 160);
            send_frame(len);
         end
      end
   endtask

   initial begin
      filter_cfg = '{server_ip: ServerIpReset, own_ip: OwnIpReset,
                     client_port: ClientPortReset, min_udp_length: MinUdpLengthReset};
      filter_frame = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gaps_on = 1'b1;
      test_reset_defaults();
      test_reason_codes();
      test_truncated_frames();
      test_long_frames();
      test_register_extremes();
      test_receiver_hold_off();
      test_random_frames(1'b1, 40, 1);
      test_random_frames(1'b0, 40, 1);
      drain();
      mismatch_count += expected_verdicts.size();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
